@@ hdl/skf_pkg.sv @@
// Shared constants and controller/datapath handshake types for the scalar Kalman filter.
package skf_pkg;

  // Default fixed-point formats
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  // Covariance and configuration word sizes
  localparam int unsigned COV_W      = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_ESTIMATE   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_COVARIANCE = 2'd3;

  // Register reset values
  localparam logic [COV_W-1:0] PROCESS_NOISE_RST      = 32'd65;
  localparam logic [COV_W-1:0] MEASUREMENT_NOISE_RST  = 32'd65536;
  localparam logic [COV_W-1:0] INITIAL_COVARIANCE_RST = 32'd65536;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted input item
    logic predict;   // apply restart, form predicted covariance and divisor
    logic div_step;  // one restoring division step of the gain
    logic multiply;  // form both gain products
    logic update;    // write back estimate and covariance
    logic out_load;  // round estimate into the output register
  } skf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;  // current division step is the last one
    logic out_free;  // output register can take a new item this cycle
  } skf_stat_t;

endpackage

@@ hdl/skf_dp.sv @@
// Datapath: configuration registers, filter state, gain divider, multipliers, output register.
module skf_dp
  import skf_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  // input item
  input  logic [SAMPLE_WIDTH-1:0] meas_i,
  input  logic                    restart_i,
  // control
  input  skf_cmd_t                cmd_i,
  output skf_stat_t               stat_o,
  // output item
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [SAMPLE_WIDTH-1:0] filt_est_o
);

  localparam int unsigned EST_W  = SAMPLE_WIDTH + FRAC_BITS;
  localparam int unsigned DIFF_W = EST_W + 1;
  localparam int unsigned GAIN_W = FRAC_BITS + 1;
  localparam int unsigned PE_W   = DIFF_W + GAIN_W + 1;
  localparam int unsigned PC_W   = COV_W + GAIN_W;
  localparam int unsigned DEN_W  = COV_W + 1;
  localparam int unsigned CNT_W  = $clog2(FRAC_BITS + 1);

  localparam logic [COV_W-1:0]  COV_ONE  = COV_W'(1) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [EST_W:0]    EST_HALF = (EST_W + 1)'(1) << (FRAC_BITS - 1);

  // Configuration registers
  logic [COV_W-1:0]        pn_q, mn_q, init_cov_q;
  logic [SAMPLE_WIDTH-1:0] init_est_q;

  // Filter state
  logic [EST_W-1:0] est_q, est_d;
  logic [COV_W-1:0] cov_q, cov_d;

  // Captured item
  logic [SAMPLE_WIDTH-1:0] meas_q;
  logic                    restart_q;

  // Prediction and divider registers
  logic [COV_W-1:0]  p_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic              nbit_q;
  logic [GAIN_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;

  // Product registers
  logic signed [PE_W-1:0] prod_e_q;
  logic [PC_W-1:0]        prod_c_q;

  // Output register
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] filt_est_q, filt_est_d;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q       <= PROCESS_NOISE_RST;
      mn_q       <= MEASUREMENT_NOISE_RST;
      init_est_q <= '0;
      init_cov_q <= INITIAL_COVARIANCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PROCESS_NOISE:      pn_q       <= cfg_wdata_i;
        REG_MEASUREMENT_NOISE:  mn_q       <= cfg_wdata_i;
        REG_INITIAL_ESTIMATE:   init_est_q <= cfg_wdata_i[SAMPLE_WIDTH-1:0];
        REG_INITIAL_COVARIANCE: init_cov_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      meas_q    <= meas_i;
      restart_q <= restart_i;
    end
  end

  // Predicted covariance, saturated, and the gain divisor
  logic [COV_W-1:0] cov_src;
  logic [COV_W:0]   p_sum;
  logic [COV_W-1:0] p_sat;
  logic [DEN_W-1:0] den_sum;

  assign cov_src = restart_q ? init_cov_q : cov_q;
  assign p_sum   = {1'b0, cov_src} + {1'b0, pn_q};
  assign p_sat   = p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
  assign den_sum = {1'b0, p_sat} + {1'b0, mn_q};

  // Restoring division step for gain = P * 2^F / den
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             trial_ge;

  assign trial     = {rem_q, nbit_q};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.predict) begin
      p_q    <= p_sat;
      den_q  <= den_sum;
      rem_q  <= {1'b0, p_sat} >> 1;
      nbit_q <= p_sat[0];
      cnt_q  <= CNT_W'(FRAC_BITS);
    end else if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q  <= {quo_q[GAIN_W-2:0], trial_ge};
      nbit_q <= 1'b0;
      cnt_q  <= cnt_q - CNT_W'(1);
    end
  end

  assign stat_o.div_last = (cnt_q == '0);

  // Gain and the two products
  logic [GAIN_W-1:0]        gain;
  logic signed [DIFF_W-1:0] diff;

  assign gain = (den_q == '0) ? '0 : quo_q;
  assign diff = signed'({meas_q[SAMPLE_WIDTH-1], meas_q, {FRAC_BITS{1'b0}}})
              - signed'({est_q[EST_W-1], est_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.multiply) begin
      prod_e_q <= PE_W'(diff) * PE_W'(signed'({1'b0, gain}));
      prod_c_q <= PC_W'(GAIN_ONE - gain) * PC_W'(p_q);
    end
  end

  // Next estimate and covariance
  always_comb begin
    est_d = est_q;
    cov_d = cov_q;
    if (cmd_i.predict && restart_q) begin
      est_d = {init_est_q, {FRAC_BITS{1'b0}}};
    end else if (cmd_i.update) begin
      est_d = est_q + prod_e_q[FRAC_BITS +: EST_W];
      cov_d = prod_c_q[FRAC_BITS +: COV_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      cov_q <= COV_ONE;
    end else begin
      est_q <= est_d;
      cov_q <= cov_d;
    end
  end

  // Round to nearest, ties up, and saturate at the top
  logic [EST_W:0]        est_rnd;
  logic [SAMPLE_WIDTH:0] est_int;

  assign est_rnd = {est_q[EST_W-1], est_q} + EST_HALF;
  assign est_int = est_rnd[FRAC_BITS +: SAMPLE_WIDTH + 1];

  always_comb begin
    if (!est_int[SAMPLE_WIDTH] && est_int[SAMPLE_WIDTH-1]) begin
      filt_est_d = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    end else begin
      filt_est_d = est_int[SAMPLE_WIDTH-1:0];
    end
  end

  // Hold the result until the output side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      filt_est_q <= filt_est_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign filt_est_o      = filt_est_q;

endmodule

@@ hdl/skf_ctrl.sv @@
// Controller: sequences one filter step through predict, divide, multiply, update and output.
module skf_ctrl
  import skf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  skf_stat_t stat_i,
  output skf_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd_o.predict = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.multiply = 1'b1;
        state_d        = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/scalar_kalman_filter.sv @@
// An accepted item goes through prediction, gain division (one quotient bit per cycle),
// multiply, update and the output load, which waits for a free output register; until then
// no input is accepted. The next item is accepted while the previous result still waits in
// the output register. Reset (rst_ni low, asynchronous): configuration registers take
// their reset values, the estimate is zero, covariance is one, no result is pending.
module scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0]                   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]                   cfg_wdata_i,
  // input stream
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata_i,  // measurement
  input  logic                                    s_axis_tuser_i,  // restart
  // output stream
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata_o   // filtered_estimate
);

  localparam int unsigned TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  skf_cmd_t                cmd;
  skf_stat_t               stat;
  logic                    in_accept;
  logic [SAMPLE_WIDTH-1:0] filt_est;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;

  // Step sequencing
  skf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and state
  skf_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .meas_i      (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .restart_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .filt_est_o  (filt_est)
  );

  assign m_axis_tdata_o = TDATA_W'(filt_est);

  // Controller never loads the output register while it is still occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");

  // At most one step command is active in a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.predict, cmd.div_step, cmd.multiply, cmd.update, cmd.out_load}))
    else $error("overlapping datapath commands");

  // An accepted item blocks further input and starts prediction next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (!s_axis_tready_o && cmd.predict))
    else $error("input accepted while step in progress");

  // The capture command coincides exactly with an input accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture == in_accept)
    else $error("capture out of step with input handshake");

endmodule
